### sv/c2d_pkg.sv
// Package for the 2D valid convolution core: sizes, item kinds, job record.
// Used by c2d_front, c2d_job_fifo, c2d_back and conv2d_valid_int32_core. No dependencies.
package c2d_pkg;

  localparam int DefMaxImageCols = 1024;
  localparam int DefMaxKernelDim = 16;
  localparam int DefMaxImageRows = 4096;

  localparam int ElemW = 32;
  localparam int ImgRowsW = 13;
  localparam int ImgColsW = 11;
  localparam int KerDimW = 5;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_KERNEL_ROWS = 2'd2,
    REG_KERNEL_COLS = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_COEF  = 1'b0,
    KIND_IMAGE = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_ROW  = 2'd1,
    BK_ACC  = 2'd2,
    BK_OUT  = 2'd3
  } back_state_t;

  // One window job handed from the front to the back.
  typedef struct packed {
    logic [15:0]        col;   // column of the completing element
    logic [KerDimW-1:0] slot;  // line slot of the window's top row
    logic               last;
  } win_job_t;

endpackage

### sv/c2d_front.sv
// Front part: accepts items, tracks counters, writes kernel and line stores,
// and issues window jobs. Depends on c2d_pkg.
module c2d_front import c2d_pkg::*; #(
  parameter int MAX_IMAGE_COLS = DefMaxImageCols,
  parameter int MAX_KERNEL_DIM = DefMaxKernelDim,
  parameter int MAX_IMAGE_ROWS = DefMaxImageRows,
  localparam int KAW = $clog2(MAX_KERNEL_DIM * MAX_KERNEL_DIM),
  localparam int RAW = $clog2(MAX_KERNEL_DIM * MAX_IMAGE_COLS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                kind,
  input  logic                cfg_fire,
  input  logic [ImgRowsW-1:0] image_rows,
  input  logic [ImgColsW-1:0] image_cols,
  input  logic [KerDimW-1:0]  kernel_rows,
  input  logic [KerDimW-1:0]  kernel_cols,
  output logic                kwr_en,
  output logic [KAW-1:0]      kwr_addr,
  output logic                rwr_en,
  output logic [RAW-1:0]      rwr_addr,
  output logic                job_valid,
  output win_job_t            job
);

  logic [KAW:0]  kernel_load_count;
  logic [15:0]   image_row_pos;
  logic [15:0]   image_col_pos;
  logic [KerDimW-1:0] slot;
  logic          cfg_ok;
  logic [9:0]    ksize;
  logic          loaded;
  logic          last;

  assign ksize = 10'(kernel_rows) * 10'(kernel_cols);
  assign cfg_ok = (image_rows != '0) && (image_cols != '0) && (kernel_rows != '0)
               && (kernel_cols != '0)
               && (32'(image_rows) <= MAX_IMAGE_ROWS) && (32'(image_cols) <= MAX_IMAGE_COLS)
               && (32'(kernel_rows) <= MAX_KERNEL_DIM) && (32'(kernel_cols) <= MAX_KERNEL_DIM)
               && (13'(kernel_rows) <= image_rows) && (11'(kernel_cols) <= image_cols);
  assign loaded = (10'(kernel_load_count) >= ksize);
  assign last = (image_row_pos + 16'd1 == 16'(image_rows))
             && (image_col_pos + 16'd1 == 16'(image_cols));

  // Restart kernel address when a coefficient arrives after a full kernel.
  assign kwr_en   = in_fire && cfg_ok && (kind == KIND_COEF);
  assign kwr_addr = loaded ? '0 : KAW'(kernel_load_count);
  assign rwr_en   = in_fire && cfg_ok && (kind == KIND_IMAGE) && loaded;
  assign rwr_addr = RAW'(32'(slot) * MAX_IMAGE_COLS + 32'(image_col_pos));

  assign job_valid = rwr_en && (image_row_pos + 16'd1 >= 16'(kernel_rows))
                  && (image_col_pos + 16'd1 >= 16'(kernel_cols));
  assign job.col  = image_col_pos;
  // The window's top row sits in the slot after the current one.
  assign job.slot = (slot + 1'b1 == kernel_rows) ? '0 : slot + 1'b1;
  assign job.last = last;

  always_ff @(posedge clk) begin
    if (rst || cfg_fire || (in_fire && !cfg_ok)) begin
      kernel_load_count <= '0;
      image_row_pos <= '0;
      image_col_pos <= '0;
      slot <= '0;
    end else if (kwr_en) begin
      if (loaded) begin
        kernel_load_count <= (KAW+1)'(1);
        image_row_pos <= '0;
        image_col_pos <= '0;
        slot <= '0;
      end else begin
        kernel_load_count <= kernel_load_count + 1'b1;
      end
    end else if (rwr_en) begin
      if (last) begin
        kernel_load_count <= '0;
        image_row_pos <= '0;
        image_col_pos <= '0;
        slot <= '0;
      end else if (image_col_pos + 16'd1 >= 16'(image_cols)) begin
        image_col_pos <= '0;
        image_row_pos <= image_row_pos + 16'd1;
        slot <= (slot + 1'b1 == kernel_rows) ? '0 : slot + 1'b1;
      end else begin
        image_col_pos <= image_col_pos + 16'd1;
      end
    end
  end

endmodule

### sv/c2d_job_fifo.sv
// Short queue of window jobs between front and back parts.
// Depends on c2d_pkg.
module c2d_job_fifo import c2d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  win_job_t push_job,
  input  logic     pop,
  output logic     empty,
  output win_job_t head
);

  win_job_t    slots [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign empty = (count == 2'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### sv/c2d_back.sv
// Back part: runs one window job, one kernel row per pass, one column tap
// per cycle, with the kernel and line stores as memories. Depends on c2d_pkg.
module c2d_back import c2d_pkg::*; #(
  parameter int MAX_IMAGE_COLS = DefMaxImageCols,
  parameter int MAX_KERNEL_DIM = DefMaxKernelDim,
  localparam int KAW = $clog2(MAX_KERNEL_DIM * MAX_KERNEL_DIM),
  localparam int RAW = $clog2(MAX_KERNEL_DIM * MAX_IMAGE_COLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               kwr_en,
  input  logic [KAW-1:0]     kwr_addr,
  input  logic               rwr_en,
  input  logic [RAW-1:0]     rwr_addr,
  input  logic [ElemW-1:0]   wr_data,
  input  logic [KerDimW-1:0] kernel_rows,
  input  logic [KerDimW-1:0] kernel_cols,
  input  logic               job_ready,
  input  win_job_t           job,
  output logic               job_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ElemW-1:0]   result_value,
  output logic               last_of_job
);

  localparam int KDEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
  localparam int RDEPTH = MAX_KERNEL_DIM * MAX_IMAGE_COLS;

  logic [ElemW-1:0] kmem [KDEPTH];
  logic [ElemW-1:0] rmem [RDEPTH];
  logic [ElemW-1:0] kq;
  logic [ElemW-1:0] rq;

  back_state_t state;
  back_state_t state_next;

  win_job_t        cur;
  logic [KerDimW-1:0] i_idx;
  logic [KerDimW-1:0] j_idx;
  logic [KerDimW-1:0] slot;      // line slot for kernel row i
  logic            rd_en;
  logic            rd_live;     // read data from previous cycle is a tap
  logic [ElemW-1:0] prod;
  logic            prod_live;
  logic [ElemW-1:0] acc;
  logic            tap_last;
  logic [KAW-1:0]  k_addr;
  logic [RAW-1:0]  r_addr;
  logic [15:0]     c0;

  always_ff @(posedge clk) begin
    if (kwr_en) begin
      kmem[kwr_addr] <= wr_data;
    end
    kq <= kmem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (rwr_en) begin
      rmem[rwr_addr] <= wr_data;
    end
    rq <= rmem[r_addr];
  end

  assign c0 = cur.col + 16'd1 - 16'(kernel_cols);
  assign k_addr = KAW'(32'(kernel_rows - 1'b1 - i_idx) * 32'(kernel_cols)
                       + 32'(kernel_cols - 1'b1 - j_idx));
  assign r_addr = RAW'(32'(slot) * MAX_IMAGE_COLS + 32'(c0) + 32'(j_idx));
  assign tap_last = (i_idx + 1'b1 == kernel_rows) && (j_idx + 1'b1 == kernel_cols);
  assign busy = (state != BK_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_ready) state_next = BK_ROW;
      BK_ROW:  if (tap_last) state_next = BK_ACC;
      BK_ACC:  if (!rd_live && !prod_live) state_next = BK_OUT;
      BK_OUT:  if (!out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    rd_en = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      BK_IDLE: job_pop = job_ready;
      BK_ROW:  rd_en = 1'b1;
      BK_ACC:  ;
      BK_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Rows of the window start at line slot (row+1-kernel_rows) mod kernel_rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
      prod_live <= 1'b0;
    end else begin
      rd_live <= rd_en;
      prod_live <= rd_live;
    end
    prod <= rq * kq;
    if (job_pop) begin
      cur <= job;
      i_idx <= '0;
      j_idx <= '0;
      acc <= '0;
      // The front hands over the starting slot; row slots advance mod kr.
      slot <= job.slot;
    end else begin
      if (rd_en) begin
        if (j_idx + 1'b1 == kernel_cols) begin
          j_idx <= '0;
          i_idx <= i_idx + 1'b1;
          slot <= (slot + 1'b1 == kernel_rows) ? '0 : slot + 1'b1;
        end else begin
          j_idx <= j_idx + 1'b1;
        end
      end
      if (prod_live) begin
        acc <= acc + prod;
      end
    end
  end

  assign result_value = acc;
  assign last_of_job = cur.last;

endmodule

### sv/conv2d_valid_int32_core.sv
// Top level of the 2D valid convolution core: configuration registers,
// front part, job queue and back part. Depends on c2d_pkg and its submodules.
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, kind, element         into core
//   out      out_valid, out_stall, result_value, last_of_job  out of core
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data into core
//
// An item that completes a window keeps the input stalled until its result
// is taken: one multiply-accumulate per cycle through one kernel and one line
// memory port, plus queue, read, multiply and output stages. Other items do
// not hold the input. Reset clears counters and control; the memories keep
// their contents. The input stalls while a window is queued or in the back
// part; a stalled output holds there.
module conv2d_valid_int32_core import c2d_pkg::*; #(
  parameter int MAX_IMAGE_COLS = DefMaxImageCols,
  parameter int MAX_KERNEL_DIM = DefMaxKernelDim,
  parameter int MAX_IMAGE_ROWS = DefMaxImageRows
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [ElemW-1:0]   element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ElemW-1:0]   result_value,
  output logic               last_of_job,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int KAW = $clog2(MAX_KERNEL_DIM * MAX_KERNEL_DIM);
  localparam int RAW = $clog2(MAX_KERNEL_DIM * MAX_IMAGE_COLS);

  logic [ImgRowsW-1:0] image_rows;
  logic [ImgColsW-1:0] image_cols;
  logic [KerDimW-1:0]  kernel_rows;
  logic [KerDimW-1:0]  kernel_cols;
  logic                in_fire;
  logic                cfg_fire;
  logic                kwr_en;
  logic [KAW-1:0]      kwr_addr;
  logic                rwr_en;
  logic [RAW-1:0]      rwr_addr;
  logic                job_valid;
  win_job_t            job;
  logic                q_empty;
  logic                q_pop;
  win_job_t            q_head;
  logic                back_busy;

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid;
  // New items would overwrite store entries that a pending window still reads.
  assign in_stall = !q_empty || back_busy;
  assign in_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= ImgRowsW'(8);
      image_cols <= ImgColsW'(8);
      kernel_rows <= KerDimW'(3);
      kernel_cols <= KerDimW'(3);
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_ROWS:  image_rows <= cfg_data[ImgRowsW-1:0];
        REG_IMAGE_COLS:  image_cols <= cfg_data[ImgColsW-1:0];
        REG_KERNEL_ROWS: kernel_rows <= cfg_data[KerDimW-1:0];
        REG_KERNEL_COLS: kernel_cols <= cfg_data[KerDimW-1:0];
        default: ;
      endcase
    end
  end

  c2d_front #(
    .MAX_IMAGE_COLS(MAX_IMAGE_COLS),
    .MAX_KERNEL_DIM(MAX_KERNEL_DIM),
    .MAX_IMAGE_ROWS(MAX_IMAGE_ROWS)
  ) u_front (
    .clk, .rst, .in_fire, .kind, .cfg_fire,
    .image_rows, .image_cols, .kernel_rows, .kernel_cols,
    .kwr_en, .kwr_addr, .rwr_en, .rwr_addr, .job_valid, .job
  );

  c2d_job_fifo u_queue (
    .clk, .rst,
    .push(job_valid), .push_job(job),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  c2d_back #(
    .MAX_IMAGE_COLS(MAX_IMAGE_COLS),
    .MAX_KERNEL_DIM(MAX_KERNEL_DIM)
  ) u_back (
    .clk, .rst, .kwr_en, .kwr_addr, .rwr_en, .rwr_addr,
    .wr_data(element), .kernel_rows, .kernel_cols,
    .job_ready(!q_empty), .job(q_head), .job_pop(q_pop), .busy(back_busy),
    .out_valid, .out_stall, .result_value, .last_of_job
  );

endmodule

### sim/conv2d_valid_int32_core_checker.sv
// Checker for the 2D valid convolution core: watches the three channels,
// predicts every result from its own copy of the state and compares in order.
// Depends on c2d_pkg for the register indexes, item kinds and sizes.
`timescale 1ns / 1ps

module conv2d_valid_int32_core_checker import c2d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               kind,
  input  logic [ElemW-1:0]   element,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ElemW-1:0]   result_value,
  input  logic               last_of_job,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output logic               hung
);

  localparam int KerDepth = DefMaxKernelDim * DefMaxKernelDim;
  localparam int LineDepth = DefMaxKernelDim * DefMaxImageCols;
  localparam int HangLimit = 20000;

  typedef struct {
    logic [ElemW-1:0] value;
    logic             last;
  } conv_out_t;

  conv_out_t conv_q[$];

  logic [ImgRowsW-1:0] img_rows;
  logic [ImgColsW-1:0] img_cols;
  logic [KerDimW-1:0]  ker_rows;
  logic [KerDimW-1:0]  ker_cols;
  logic [ElemW-1:0]    coef_mem[KerDepth];
  logic [ElemW-1:0]    line_mem[LineDepth];
  int unsigned         coef_cnt;
  int unsigned         row_pos;
  int unsigned         col_pos;
  int                  quiet_cycles;

  function automatic bit dims_ok();
    if (img_rows == 0 || img_cols == 0 || ker_rows == 0 || ker_cols == 0) return 0;
    if (img_rows > DefMaxImageRows || img_cols > DefMaxImageCols) return 0;
    if (ker_rows > DefMaxKernelDim || ker_cols > DefMaxKernelDim) return 0;
    if (ker_rows > img_rows || ker_cols > img_cols) return 0;
    return 1;
  endfunction

  function automatic logic [ElemW-1:0] window_sum(int unsigned r, int unsigned c);
    int unsigned r0;
    int unsigned c0;
    int unsigned slot;
    int unsigned kbase;
    logic [ElemW-1:0] acc;
    logic [ElemW-1:0] prod;
    r0 = r + 1 - ker_rows;
    c0 = c + 1 - ker_cols;
    acc = '0;
    for (int unsigned i = 0; i < ker_rows; i++) begin
      slot = (r0 + i) % ker_rows;
      kbase = (ker_rows - 1 - i) * ker_cols;
      for (int unsigned j = 0; j < ker_cols; j++) begin
        prod = line_mem[(slot * DefMaxImageCols + c0 + j) % LineDepth]
             * coef_mem[(kbase + ker_cols - 1 - j) % KerDepth];
        acc = acc + prod;
      end
    end
    return acc;
  endfunction

  task automatic restart_job();
    coef_cnt = 0;
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic take_item(logic k, logic [ElemW-1:0] e);
    int unsigned ksize;
    int unsigned r;
    int unsigned c;
    logic fin;
    conv_out_t res;
    if (!dims_ok()) begin
      restart_job();
      return;
    end
    ksize = ker_rows * ker_cols;
    if (k == KIND_COEF) begin
      // A coefficient after a complete kernel starts a new job.
      if (coef_cnt >= ksize) restart_job();
      coef_mem[coef_cnt % KerDepth] = e;
      coef_cnt++;
      return;
    end
    if (coef_cnt < ksize) return;
    r = row_pos;
    c = col_pos;
    line_mem[((r % ker_rows) * DefMaxImageCols + c) % LineDepth] = e;
    fin = (r + 1 == img_rows) && (c + 1 == img_cols);
    if (fin) begin
      restart_job();
    end else if (c + 1 >= img_cols) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (r + 1 >= ker_rows && c + 1 >= ker_cols) begin
      res.value = window_sum(r, c);
      res.last = fin;
      conv_q.push_back(res);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
    case (cfg_reg_t'(idx))
      REG_IMAGE_ROWS:  img_rows = d[ImgRowsW-1:0];
      REG_IMAGE_COLS:  img_cols = d[ImgColsW-1:0];
      REG_KERNEL_ROWS: ker_rows = d[KerDimW-1:0];
      REG_KERNEL_COLS: ker_cols = d[KerDimW-1:0];
      default: return;
    endcase
    restart_job();
  endtask

  initial begin
    errors = 0;
    hung = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    conv_out_t want;
    if (rst) begin
      img_rows = 8;
      img_cols = 8;
      ker_rows = 3;
      ker_cols = 3;
      restart_job();
      conv_q.delete();
      quiet_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (conv_q.size() == 0) begin
          $error("result_value: no result expected, actual %0h", result_value);
          errors++;
        end else begin
          want = conv_q.pop_front();
          if (result_value !== want.value) begin
            $error("result_value: expected %0h, actual %0h", want.value, result_value);
            errors++;
          end
          if (last_of_job !== want.last) begin
            $error("last_of_job: expected %0b, actual %0b", want.last, last_of_job);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) take_item(kind, element);
      if ((out_valid && !out_stall) || (cfg_valid && cfg_ready) || (in_valid && !in_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= HangLimit) hung <= 1;
    end
    pending <= conv_q.size();
  end

endmodule

### sim/conv2d_valid_int32_core_tb.sv
// Testbench top for the 2D valid convolution core: clock, reset, stimulus
// and verdict. Depends on c2d_pkg, the core and conv2d_valid_int32_core_checker.
`timescale 1ns / 1ps

module conv2d_valid_int32_core_tb import c2d_pkg::*;;

  localparam int RandItems = 1400;
  localparam int CalmAfter = 1250;
  localparam int DrainWait = 300;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic [ElemW-1:0]   element;
  logic               out_valid;
  logic               out_stall;
  logic [ElemW-1:0]   result_value;
  logic               last_of_job;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;
  int                 errors;
  int                 pending;
  logic               hung;
  bit                 calm = 0;
  int                 sent = 0;
  int                 stall_left = 0;

  conv2d_valid_int32_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .element(element),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .last_of_job(last_of_job),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  conv2d_valid_int32_core_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .element(element),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .last_of_job(last_of_job),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .hung(hung)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (hung) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [ElemW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return ElemW'($urandom_range(0, 7)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Registers are only written with no item in flight.
  task automatic wait_drained();
    in_valid <= 0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    bit taken;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 0;
  endtask

  // Upper data bits beyond the register width are filled with noise.
  task automatic set_dims(logic [31:0] ir, logic [31:0] ic, logic [31:0] kr, logic [31:0] kc);
    wait_drained();
    write_reg(REG_IMAGE_ROWS, ir | ($urandom << ImgRowsW));
    write_reg(REG_IMAGE_COLS, ic | ($urandom << ImgColsW));
    write_reg(REG_KERNEL_ROWS, kr | ($urandom << KerDimW));
    write_reg(REG_KERNEL_COLS, kc | ($urandom << KerDimW));
  endtask

  task automatic send_item(item_kind_t k, logic [ElemW-1:0] v);
    bit taken;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    element <= v;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent++;
    if (sent > CalmAfter) calm = 1;
  endtask

  // A well-formed job with a little noise in the item kinds; cap cuts it short.
  task automatic send_job(int ir, int ic, int kr, int kc, int cap);
    int total;
    item_kind_t k;
    total = kr * kc + ir * ic;
    for (int i = 0; i < total && i < cap; i++) begin
      k = (i < kr * kc) ? KIND_COEF : KIND_IMAGE;
      if ($urandom_range(0, 24) == 0) k = item_kind_t'($urandom_range(0, 1));
      send_item(k, pick_value());
    end
  endtask

  task automatic random_phase();
    int sel;
    int ir;
    int ic;
    int kr;
    int kc;
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      set_dims($urandom, $urandom, $urandom, $urandom);
      repeat (10) send_item(item_kind_t'($urandom_range(0, 1)), pick_value());
    end else if (sel == 2) begin
      kr = $urandom_range(1, 16);
      kc = $urandom_range(1, 16);
      ir = $urandom_range(kr, 4096);
      ic = $urandom_range(kc, 1024);
      set_dims(ir, ic, kr, kc);
      send_job(ir, ic, kr, kc, 300);
    end else begin
      ir = $urandom_range(1, 6);
      ic = $urandom_range(1, 8);
      kr = $urandom_range(1, (ir < 4) ? ir : 4);
      kc = $urandom_range(1, (ic < 4) ? ic : 4);
      set_dims(ir, ic, kr, kc);
      repeat ($urandom_range(1, 3)) send_job(ir, ic, kr, kc, 1000);
    end
  endtask

  initial begin
    in_valid <= 0;
    kind <= KIND_COEF;
    element <= '0;
    cfg_valid <= 0;
    cfg_index <= REG_IMAGE_ROWS;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Image 2x3, kernel 2x2, extreme values.
    set_dims(2, 3, 2, 2);
    send_item(KIND_IMAGE, 32'h1234_5678);  // ignored while the kernel loads
    send_item(KIND_COEF, 32'h8000_0000);
    send_item(KIND_COEF, 32'h7fff_ffff);
    send_item(KIND_COEF, 32'hffff_ffff);
    send_item(KIND_COEF, 32'h0000_0001);
    send_item(KIND_IMAGE, 32'h7fff_ffff);
    send_item(KIND_IMAGE, 32'h8000_0000);
    send_item(KIND_IMAGE, 32'hffff_ffff);
    // A coefficient in the image phase aborts and opens a new kernel.
    send_item(KIND_COEF, 32'h7fff_ffff);
    send_item(KIND_COEF, 32'h8000_0000);
    send_item(KIND_COEF, 32'hffff_ffff);
    send_item(KIND_COEF, 32'h8000_0000);
    send_item(KIND_IMAGE, 32'h8000_0000);
    send_item(KIND_IMAGE, 32'h7fff_ffff);
    send_item(KIND_IMAGE, 32'h0);
    send_item(KIND_IMAGE, 32'hffff_ffff);
    send_item(KIND_IMAGE, 32'h8000_0000);
    send_item(KIND_IMAGE, 32'h7fff_ffff);
    // Kernel larger than the image: everything is ignored.
    set_dims(2, 3, 3, 1);
    send_item(KIND_COEF, 32'h5);
    send_item(KIND_IMAGE, 32'h6);
    // Largest sizes, cut short before any window completes.
    set_dims(4096, 1024, 16, 16);
    send_job(4096, 1024, 16, 16, 280);

    sent = 0;
    while (sent < RandItems) random_phase();

    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
